// ===== rtl/core/ngs_pkg.sv =====
// shared types, constants and helpers for the gravity step block
package ngs_pkg;

   localparam int MAX_BODIES = 16;
   localparam int IDX_W      = $clog2(MAX_BODIES);
   localparam int CNT_W      = $clog2(MAX_BODIES + 1);

   localparam logic [4:0]   COUNT_RESET = 5'd3;
   localparam logic [127:0] K_1E8       = 128'd100000000;
   localparam logic [127:0] K_1000      = 128'd1000;
   localparam logic [127:0] K_2000      = 128'd2000;
   localparam logic [46:0]  SMAX47      = {47{1'b1}};

   localparam logic signed [51:0] SAT_HI = 52'sh0_7FFF_FFFF_FFFF;
   localparam logic signed [51:0] SAT_LO = -52'sh0_8000_0000_0000;

   localparam logic [0:0] KIND_WRITE = 1'b0;
   localparam logic [0:0] KIND_TICK  = 1'b1;

   // byte address of the body count register
   localparam logic [2:0] ADDR_BODY_COUNT = 3'd0;

   typedef enum logic [1:0] {
      ALU_MUL  = 2'd0,
      ALU_DIV  = 2'd1,
      ALU_SQRT = 2'd2
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } alu_stat_type;

   // clamp to the signed 48-bit range
   function automatic logic [47:0] sat48(input logic signed [51:0] v);
      logic [47:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[47:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[47:0];
      end else begin
         r = v[47:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/ngs_alu.sv =====
// shared iterative unit: shift-add multiply, restoring divide, integer square root
module ngs_alu (
   input  logic                  clock,
   input  logic                  reset,
   input  ngs_pkg::alu_ctrl_type ctrl,
   input  logic [127:0]          a,
   input  logic [127:0]          b,
   output ngs_pkg::alu_stat_type stat,
   output logic [127:0]          result
);

   logic                busy_ff;
   logic                done_ff;
   logic [6:0]          cnt_ff;
   ngs_pkg::alu_op_type op_ff;
   logic [127:0]        acc_ff;
   logic [127:0]        x_ff;
   logic [127:0]        y_ff;
   logic [128:0]        rem_ff;

   logic [128:0] div_sh;
   logic [128:0] sq_sh;
   logic [128:0] sq_trial;

   assign div_sh   = {rem_ff[127:0], x_ff[127]};
   assign sq_sh    = {rem_ff[126:0], x_ff[127:126]};
   assign sq_trial = {acc_ff[126:0], 2'b01};

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.start) begin
            busy_ff <= 1'b1;
            unique case (ctrl.op)
               ngs_pkg::ALU_DIV: cnt_ff <= 7'd127;
               default:          cnt_ff <= 7'd63;
            endcase
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 7'd1;
            if (cnt_ff == 7'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         op_ff  <= ctrl.op;
         acc_ff <= '0;
         x_ff   <= a;
         y_ff   <= b;
         rem_ff <= '0;
      end else if (busy_ff) begin
         unique case (op_ff)
            ngs_pkg::ALU_MUL: begin
               if (y_ff[0]) begin
                  acc_ff <= acc_ff + x_ff;
               end
               x_ff <= {x_ff[126:0], 1'b0};
               y_ff <= {1'b0, y_ff[127:1]};
            end
            ngs_pkg::ALU_DIV: begin
               x_ff <= {x_ff[126:0], 1'b0};
               if (div_sh >= {1'b0, y_ff}) begin
                  rem_ff <= div_sh - {1'b0, y_ff};
                  acc_ff <= {acc_ff[126:0], 1'b1};
               end else begin
                  rem_ff <= div_sh;
                  acc_ff <= {acc_ff[126:0], 1'b0};
               end
            end
            default: begin
               x_ff <= {x_ff[125:0], 2'b00};
               if (sq_sh >= sq_trial) begin
                  rem_ff <= sq_sh - sq_trial;
                  acc_ff <= {acc_ff[126:0], 1'b1};
               end else begin
                  rem_ff <= sq_sh;
                  acc_ff <= {acc_ff[126:0], 1'b0};
               end
            end
         endcase
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = acc_ff;

endmodule

// ===== rtl/core/nbody_gravity_step.sv =====
// top level of the direct all-pairs gravity step over a body table
// A write transaction (req_kind 0) loads one body. A tick transaction
// (req_kind 1) runs one gravity step over bodies 0..body_count-1, with the
// body count limited to 16, and then reports each body's new position as one
// strobed result on rsp_valid, in index order, rsp_last on the final one;
// results cannot be held off. All arithmetic goes through one shared
// iterative unit, one operation at a time. Each ordered pair of distinct,
// separated bodies with a movable first body costs 7 multiplies, 3 divides
// and one square root; each body in use then costs 2 multiplies and 2
// divides for the move. A tick with a body count of zero returns nothing
// and leaves busy low. busy rises at the edge after a tick is taken and
// falls again in the cycle that carries the final result.
module nbody_gravity_step (
   input  logic         clock,
   input  logic         reset,
   // item channel
   input  logic         start,
   output logic         busy,
   input  logic         req_kind,
   input  logic [3:0]   req_body_index,
   input  logic [47:0]  req_pos_x_in,
   input  logic [47:0]  req_pos_y_in,
   input  logic [47:0]  req_vel_x_in,
   input  logic [47:0]  req_vel_y_in,
   input  logic [21:0]  req_mass_in,
   input  logic         req_movable_in,
   // result channel
   output logic         rsp_valid,
   output logic [3:0]   rsp_out_index,
   output logic [47:0]  rsp_pos_x_out,
   output logic [47:0]  rsp_pos_y_out,
   output logic         rsp_last,
   // register port
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int IW = ngs_pkg::IDX_W;
   localparam int CW = ngs_pkg::CNT_W;

   // one-hot sequencer
   typedef enum logic [17:0] {
      ST_IDLE  = 18'b000000000000000001,
      ST_LOADI = 18'b000000000000000010,
      ST_PAIR  = 18'b000000000000000100,
      ST_MDX   = 18'b000000000000001000,
      ST_MDY   = 18'b000000000000010000,
      ST_SQRT  = 18'b000000000000100000,
      ST_MWW   = 18'b000000000001000000,
      ST_MDEN  = 18'b000000000010000000,
      ST_DIVF  = 18'b000000000100000000,
      ST_MKD   = 18'b000000001000000000,
      ST_MPX   = 18'b000000010000000000,
      ST_DPX   = 18'b000000100000000000,
      ST_MPY   = 18'b000001000000000000,
      ST_DPY   = 18'b000010000000000000,
      ST_MVXM  = 18'b000100000000000000,
      ST_MVXD  = 18'b001000000000000000,
      ST_MVYM  = 18'b010000000000000000,
      ST_MVYD  = 18'b100000000000000000
   } state_type;

   state_type state_ff;

   // body table, read at one address at a time
   logic [47:0] pos_x_ff [ngs_pkg::MAX_BODIES];
   logic [47:0] pos_y_ff [ngs_pkg::MAX_BODIES];
   logic [47:0] vel_x_ff [ngs_pkg::MAX_BODIES];
   logic [47:0] vel_y_ff [ngs_pkg::MAX_BODIES];
   logic [21:0] mass_ff  [ngs_pkg::MAX_BODIES];
   logic        mov_ff   [ngs_pkg::MAX_BODIES];

   logic [4:0]  count_ff;
   logic [CW-1:0] n_ff;
   logic [CW-1:0] i_ff;
   logic [CW-1:0] j_ff;
   logic        op_run_ff;

   // working registers
   logic [47:0]        xi_ff, yi_ff, vx_ff, vy_ff;
   logic [21:0]        wi_ff;
   logic signed [48:0] dx_ff, dy_ff;
   logic [127:0]       t_ff;
   logic [127:0]       den_ff;
   logic [63:0]        d_ff, f_ff, kd_ff, mv_ff;
   logic [43:0]        ww_ff;
   logic [47:0]        nx_ff;

   // result registers
   logic        rsp_valid_ff;
   logic [3:0]  rsp_index_ff;
   logic [47:0] rsp_x_ff, rsp_y_ff;
   logic        rsp_last_ff;

   logic [IW-1:0] rd_idx;
   logic [47:0]   rd_px, rd_py, rd_vx, rd_vy;
   logic [21:0]   rd_m;
   logic          rd_mov;

   logic signed [48:0] dxn, dyn;
   logic [48:0]        adx, ady;
   logic [47:0]        avx, avy;
   logic [CW-1:0]      n_lim;

   ngs_pkg::alu_ctrl_type alu_ctrl;
   ngs_pkg::alu_stat_type alu_stat;
   logic [127:0]          alu_a, alu_b, alu_res;
   ngs_pkg::alu_op_type   alu_op;
   logic                  is_op;
   logic                  op_done;

   logic [47:0]        pull_m;
   logic signed [51:0] pull_x, pull_y;
   logic signed [51:0] mv_delta;
   logic [47:0]        mv_new;
   logic [47:0]        mv_pos;

   // single read port into the table
   assign rd_idx = (state_ff == ST_LOADI) ? i_ff[IW-1:0] : j_ff[IW-1:0];
   assign rd_px  = pos_x_ff[rd_idx];
   assign rd_py  = pos_y_ff[rd_idx];
   assign rd_vx  = vel_x_ff[rd_idx];
   assign rd_vy  = vel_y_ff[rd_idx];
   assign rd_m   = mass_ff[rd_idx];
   assign rd_mov = mov_ff[rd_idx];

   // pair offsets and magnitudes
   assign dxn = {rd_px[47], rd_px} - {xi_ff[47], xi_ff};
   assign dyn = {rd_py[47], rd_py} - {yi_ff[47], yi_ff};
   assign adx = dx_ff[48] ? 49'(-dx_ff) : 49'(dx_ff);
   assign ady = dy_ff[48] ? 49'(-dy_ff) : 49'(dy_ff);
   assign avx = rd_vx[47] ? 48'(-rd_vx) : rd_vx;
   assign avy = rd_vy[47] ? 48'(-rd_vy) : rd_vy;

   // body count limited to the table depth
   assign n_lim = (count_ff > 5'(ngs_pkg::MAX_BODIES)) ?
                  CW'(ngs_pkg::MAX_BODIES) : CW'(count_ff);

   // velocity change from one division, saturated, with the offset's sign
   assign pull_m = (alu_res[127:47] != '0) ? {1'b0, ngs_pkg::SMAX47} : alu_res[47:0];
   assign pull_x = dx_ff[48] ? -52'(signed'({4'b0, pull_m})) : 52'(signed'({4'b0, pull_m}));
   assign pull_y = dy_ff[48] ? -52'(signed'({4'b0, pull_m})) : 52'(signed'({4'b0, pull_m}));

   // move step: quotient is below 2^51, sign follows the velocity
   assign mv_pos   = (state_ff == ST_MVXD) ? rd_px : rd_py;
   always_comb begin
      if ((state_ff == ST_MVXD) ? rd_vx[47] : rd_vy[47]) begin
         mv_delta = -52'(signed'({1'b0, alu_res[50:0]}));
      end else begin
         mv_delta = 52'(signed'({1'b0, alu_res[50:0]}));
      end
      if (rd_m == '0) begin
         mv_new = mv_pos;
      end else begin
         mv_new = ngs_pkg::sat48(52'(signed'(mv_pos)) + mv_delta);
      end
   end

   // operand selection for the shared unit
   always_comb begin
      alu_a  = '0;
      alu_b  = '0;
      alu_op = ngs_pkg::ALU_MUL;
      is_op  = 1'b1;
      unique case (state_ff)
         ST_MDX: begin
            alu_a = 128'(adx);
            alu_b = 128'(adx);
         end
         ST_MDY: begin
            alu_a = 128'(ady);
            alu_b = 128'(ady);
         end
         ST_SQRT: begin
            alu_a  = t_ff;
            alu_op = ngs_pkg::ALU_SQRT;
         end
         ST_MWW: begin
            alu_a = 128'(wi_ff);
            alu_b = 128'(rd_m);
         end
         ST_MDEN: begin
            alu_a = t_ff;
            alu_b = ngs_pkg::K_1E8;
         end
         ST_DIVF: begin
            alu_a  = {4'b0, ww_ff, 80'b0};
            alu_b  = den_ff;
            alu_op = ngs_pkg::ALU_DIV;
         end
         ST_MKD: begin
            alu_a = 128'(d_ff);
            alu_b = ngs_pkg::K_1000;
         end
         ST_MPX: begin
            alu_a = 128'(f_ff);
            alu_b = 128'(adx);
         end
         ST_MPY: begin
            alu_a = 128'(f_ff);
            alu_b = 128'(ady);
         end
         ST_DPX, ST_DPY: begin
            alu_a  = t_ff;
            alu_b  = 128'(kd_ff);
            alu_op = ngs_pkg::ALU_DIV;
         end
         ST_MVXM: begin
            alu_a = 128'(avx);
            alu_b = ngs_pkg::K_2000;
         end
         ST_MVYM: begin
            alu_a = 128'(avy);
            alu_b = ngs_pkg::K_2000;
         end
         ST_MVXD, ST_MVYD: begin
            alu_a  = 128'(mv_ff);
            alu_b  = 128'({rd_m, 8'b0});
            alu_op = ngs_pkg::ALU_DIV;
         end
         default: begin
            is_op = 1'b0;
         end
      endcase
   end

   assign alu_ctrl.start = is_op && !op_run_ff;
   assign alu_ctrl.op    = alu_op;
   assign op_done        = is_op && op_run_ff && alu_stat.done;

   ngs_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (alu_ctrl),
      .a      (alu_a),
      .b      (alu_b),
      .stat   (alu_stat),
      .result (alu_res)
   );

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_run_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= ngs_pkg::COUNT_RESET;
         n_ff         <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (alu_ctrl.start) begin
            op_run_ff <= 1'b1;
         end else if (op_done) begin
            op_run_ff <= 1'b0;
         end

         // register write, block idle by contract
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && !csr_paddr[2]) begin
            count_ff <= csr_pwdata[4:0];
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (start && req_kind == ngs_pkg::KIND_TICK && n_lim != '0) begin
                  n_ff     <= n_lim;
                  i_ff     <= '0;
                  state_ff <= ST_LOADI;
               end
            end
            ST_LOADI: begin
               if (i_ff == n_ff) begin
                  j_ff     <= '0;
                  state_ff <= ST_MVXM;
               end else if (!rd_mov) begin
                  i_ff <= i_ff + CW'(1);
               end else begin
                  j_ff     <= '0;
                  state_ff <= ST_PAIR;
               end
            end
            ST_PAIR: begin
               if (j_ff == n_ff) begin
                  i_ff     <= i_ff + CW'(1);
                  state_ff <= ST_LOADI;
               end else if (j_ff == i_ff || (dxn == '0 && dyn == '0)) begin
                  j_ff <= j_ff + CW'(1);
               end else begin
                  state_ff <= ST_MDX;
               end
            end
            ST_MDX:  if (op_done) state_ff <= ST_MDY;
            ST_MDY:  if (op_done) state_ff <= ST_SQRT;
            ST_SQRT: if (op_done) state_ff <= ST_MWW;
            ST_MWW:  if (op_done) state_ff <= ST_MDEN;
            ST_MDEN: if (op_done) state_ff <= ST_DIVF;
            ST_DIVF: if (op_done) state_ff <= ST_MKD;
            ST_MKD:  if (op_done) state_ff <= ST_MPX;
            ST_MPX:  if (op_done) state_ff <= ST_DPX;
            ST_DPX:  if (op_done) state_ff <= ST_MPY;
            ST_MPY:  if (op_done) state_ff <= ST_DPY;
            ST_DPY: begin
               if (op_done) begin
                  j_ff     <= j_ff + CW'(1);
                  state_ff <= ST_PAIR;
               end
            end
            ST_MVXM: if (op_done) state_ff <= ST_MVXD;
            ST_MVXD: if (op_done) state_ff <= ST_MVYM;
            ST_MVYM: if (op_done) state_ff <= ST_MVYD;
            ST_MVYD: begin
               if (op_done) begin
                  // one result transaction per body
                  rsp_valid_ff <= 1'b1;
                  j_ff         <= j_ff + CW'(1);
                  if (j_ff + CW'(1) == n_ff) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     state_ff <= ST_MVXM;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // datapath and table updates
   always_ff @(posedge clock) begin
      // body load from a write transaction
      if (state_ff == ST_IDLE && start && req_kind == ngs_pkg::KIND_WRITE &&
          32'(req_body_index) < ngs_pkg::MAX_BODIES) begin
         pos_x_ff[req_body_index[IW-1:0]] <= req_pos_x_in;
         pos_y_ff[req_body_index[IW-1:0]] <= req_pos_y_in;
         vel_x_ff[req_body_index[IW-1:0]] <= req_vel_x_in;
         vel_y_ff[req_body_index[IW-1:0]] <= req_vel_y_in;
         mass_ff[req_body_index[IW-1:0]]  <= req_mass_in;
         mov_ff[req_body_index[IW-1:0]]   <= req_movable_in;
      end

      // latch body i
      if (state_ff == ST_LOADI) begin
         xi_ff <= rd_px;
         yi_ff <= rd_py;
         wi_ff <= rd_m;
         vx_ff <= rd_vx;
         vy_ff <= rd_vy;
      end

      if (state_ff == ST_PAIR) begin
         dx_ff <= dxn;
         dy_ff <= dyn;
         // velocity of body i after all its pairs
         if (j_ff == n_ff) begin
            vel_x_ff[i_ff[IW-1:0]] <= vx_ff;
            vel_y_ff[i_ff[IW-1:0]] <= vy_ff;
         end
      end

      if (op_done) begin
         unique case (state_ff)
            ST_MDX:  t_ff   <= alu_res;
            ST_MDY:  t_ff   <= t_ff + alu_res;
            ST_SQRT: d_ff   <= alu_res[63:0];
            ST_MWW:  ww_ff  <= alu_res[43:0];
            ST_MDEN: den_ff <= alu_res;
            ST_DIVF: f_ff   <= (alu_res[127:64] != '0) ? {64{1'b1}} : alu_res[63:0];
            ST_MKD:  kd_ff  <= alu_res[63:0];
            ST_MPX, ST_MPY: t_ff <= alu_res;
            ST_DPX:  vx_ff  <= ngs_pkg::sat48(52'(signed'(vx_ff)) + pull_x);
            ST_DPY:  vy_ff  <= ngs_pkg::sat48(52'(signed'(vy_ff)) + pull_y);
            ST_MVXM, ST_MVYM: mv_ff <= alu_res[63:0];
            ST_MVXD: nx_ff  <= mv_new;
            ST_MVYD: begin
               pos_x_ff[j_ff[IW-1:0]] <= nx_ff;
               pos_y_ff[j_ff[IW-1:0]] <= mv_new;
               rsp_index_ff <= 4'(j_ff);
               rsp_x_ff     <= nx_ff;
               rsp_y_ff     <= mv_new;
               rsp_last_ff  <= (j_ff + CW'(1) == n_ff);
            end
            default: begin
            end
         endcase
      end
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_pos_x_out = rsp_x_ff;
   assign rsp_pos_y_out = rsp_y_ff;
   assign rsp_last      = rsp_last_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {27'd0, count_ff};

   // the shared unit is only launched while it is free
   assert property (@(posedge clock) disable iff (reset)
      alu_ctrl.start |-> !alu_stat.busy)
      else $error("shared unit launched while busy");

   // results are never back to back
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobes back to back");

   // a result that is not the final one leaves the tick running
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("tick ended before the final result");

endmodule
